[hw/rtl/tcce_pkg.sv]
// Shared constants and address helpers for the text console character engine.
package tcce_pkg;

  localparam int VRAM_WORDS  = 8192;
  localparam int LINE_CHARS  = 80;
  localparam int SCREEN_ROWS = 25;

  localparam int ADDR_W = $clog2(VRAM_WORDS);
  localparam int ROW_W  = $clog2(SCREEN_ROWS);
  localparam int COL_W  = $clog2(LINE_CHARS);
  localparam int WORD_W = 16;
  localparam int CHAR_W = 8;
  localparam int SUM_W  = ADDR_W + 2;

  localparam int COPY_WORDS = (SCREEN_ROWS - 1) * LINE_CHARS;
  localparam int IDX_W      = $clog2(COPY_WORDS);

  localparam logic [WORD_W-1:0] BLANK_WORD  = 16'h0700;
  localparam logic [WORD_W-1:0] SCROLL_FILL = 16'h0C00;
  localparam logic [CHAR_W-1:0] ATTR_RESET  = 8'h0E;

  localparam logic [CHAR_W-1:0] CH_LF = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_BS = 8'h08;

  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  localparam logic [SUM_W-1:0] LINE_SUM     = SUM_W'(LINE_CHARS);
  localparam logic [SUM_W-1:0] SCROLL_LIMIT = SUM_W'((SCREEN_ROWS + 1) * LINE_CHARS);
  localparam logic [SUM_W-1:0] VRAM_SUM     = SUM_W'(VRAM_WORDS);
  localparam logic [SUM_W-1:0] BOTTOM_OFS   = SUM_W'(COPY_WORDS);

  // origin + row * LINE_CHARS + column, unwrapped
  function automatic logic [SUM_W-1:0] cursor_sum(input logic [ADDR_W-1:0] origin,
                                                  input logic [ROW_W-1:0]  row,
                                                  input logic [COL_W-1:0]  col);
    logic [SUM_W-1:0] line_base;
    line_base = SUM_W'(row) * LINE_SUM;
    return SUM_W'(origin) + line_base + SUM_W'(col);
  endfunction

endpackage

[hw/rtl/text_console_char_engine.sv]
// Console character engine top: a put goes via ST_DONE to the output register, a read via
// ST_RD_WAIT (registered RAM read) and ST_DONE; ST_DONE holds while the output is stalled.
// One item at a time; next input taken as the result registers. A scroll that moves the
// origin adds a bottom-row fill of LINE_CHARS words; one that wraps to the base first copies
// (SCREEN_ROWS-1)*LINE_CHARS words (read then write), then fills. After reset a clearing pass
// writes BLANK_WORD to all VRAM_WORDS entries, in_stall high; cfg writes taken throughout.
module text_console_char_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_func,
  input  logic [tcce_pkg::CHAR_W-1:0]   in_char_code,
  input  logic [tcce_pkg::ADDR_W-1:0]   in_read_address,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tcce_pkg::ADDR_W-1:0]   out_cursor_address,
  output logic [tcce_pkg::ADDR_W-1:0]   out_display_origin,
  output logic [tcce_pkg::WORD_W-1:0]   out_read_data,
  input  logic                          cfg_we,
  input  logic [tcce_pkg::CHAR_W-1:0]   cfg_wdata
);

  typedef enum logic [6:0] {
    ST_CLEAR   = 7'b0000001,
    ST_IDLE    = 7'b0000010,
    ST_RD_WAIT = 7'b0000100,
    ST_COPY_RD = 7'b0001000,
    ST_COPY_WR = 7'b0010000,
    ST_FILL    = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [tcce_pkg::ADDR_W-1:0] clr_r, clr_nxt;
  logic [tcce_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [tcce_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [tcce_pkg::ADDR_W-1:0] origin_r, origin_nxt;
  logic [tcce_pkg::CHAR_W-1:0] attr_r;
  logic [tcce_pkg::IDX_W-1:0]  idx_r, idx_nxt;
  logic [tcce_pkg::ADDR_W-1:0] fill_base_r, fill_base_nxt;
  logic [tcce_pkg::WORD_W-1:0] data_r, data_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [tcce_pkg::ADDR_W-1:0] out_cur_r, out_cur_nxt;
  logic [tcce_pkg::ADDR_W-1:0] out_org_r, out_org_nxt;
  logic [tcce_pkg::WORD_W-1:0] out_data_r, out_data_nxt;

  logic                        ram_we;
  logic [tcce_pkg::ADDR_W-1:0] ram_waddr;
  logic [tcce_pkg::WORD_W-1:0] ram_wdata;
  logic [tcce_pkg::ADDR_W-1:0] ram_raddr;
  logic [tcce_pkg::WORD_W-1:0] ram_rdata;

  logic [tcce_pkg::SUM_W-1:0]  cur_sum;

  tcce_ram #(
    .WIDTH (tcce_pkg::WORD_W),
    .DEPTH (tcce_pkg::VRAM_WORDS)
  ) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur_sum = tcce_pkg::cursor_sum(origin_r, row_r, col_r);

  always_comb begin
    logic                       down;
    logic [tcce_pkg::SUM_W-1:0] adv_origin;
    down          = 1'b0;
    adv_origin    = tcce_pkg::SUM_W'(origin_r) + tcce_pkg::LINE_SUM;
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    origin_nxt    = origin_r;
    idx_nxt       = idx_r;
    fill_base_nxt = fill_base_r;
    data_nxt      = data_r;
    out_valid_nxt = out_valid_r;
    out_cur_nxt   = out_cur_r;
    out_org_nxt   = out_org_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = tcce_pkg::BLANK_WORD;
        clr_nxt   = clr_r + tcce_pkg::ADDR_W'(1);
        if (clr_r == tcce_pkg::ADDR_W'(tcce_pkg::VRAM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          data_nxt = '0;
          if (in_func == tcce_pkg::FUNC_READ) begin
            ram_raddr = in_read_address;
            state_nxt = ST_RD_WAIT;
          end else begin
            state_nxt = ST_DONE;
            case (in_char_code)
              tcce_pkg::CH_LF: begin
                down = 1'b1;
              end
              tcce_pkg::CH_CR: begin
                col_nxt = '0;
              end
              tcce_pkg::CH_BS: begin
                if (col_r != '0) begin
                  col_nxt   = col_r - tcce_pkg::COL_W'(1);
                  ram_we    = 1'b1;
                  ram_waddr = tcce_pkg::ADDR_W'(cur_sum - tcce_pkg::SUM_W'(1));
                  ram_wdata = tcce_pkg::BLANK_WORD;
                end
              end
              default: begin
                ram_we    = 1'b1;
                ram_waddr = tcce_pkg::ADDR_W'(cur_sum);
                ram_wdata = {attr_r, in_char_code};
                if (col_r == tcce_pkg::COL_W'(tcce_pkg::LINE_CHARS - 1)) begin
                  col_nxt = '0;
                  down    = 1'b1;
                end else begin
                  col_nxt = col_r + tcce_pkg::COL_W'(1);
                end
              end
            endcase
            if (down) begin
              if (row_r == tcce_pkg::ROW_W'(tcce_pkg::SCREEN_ROWS - 1)) begin
                idx_nxt = '0;
                // room for one more line: slide the origin, else wrap to the base
                if (tcce_pkg::SUM_W'(origin_r) + tcce_pkg::SCROLL_LIMIT < tcce_pkg::VRAM_SUM) begin
                  origin_nxt    = tcce_pkg::ADDR_W'(adv_origin);
                  fill_base_nxt = tcce_pkg::ADDR_W'(adv_origin + tcce_pkg::BOTTOM_OFS);
                  state_nxt     = ST_FILL;
                end else begin
                  state_nxt = ST_COPY_RD;
                end
              end else begin
                row_nxt = row_r + tcce_pkg::ROW_W'(1);
              end
            end
          end
        end
      end
      ST_RD_WAIT: begin
        data_nxt  = ram_rdata;
        state_nxt = ST_DONE;
      end
      ST_COPY_RD: begin
        ram_raddr = tcce_pkg::ADDR_W'(adv_origin + tcce_pkg::SUM_W'(idx_r));
        state_nxt = ST_COPY_WR;
      end
      ST_COPY_WR: begin
        ram_we    = 1'b1;
        ram_waddr = tcce_pkg::ADDR_W'(idx_r);
        ram_wdata = ram_rdata;
        if (idx_r == tcce_pkg::IDX_W'(tcce_pkg::COPY_WORDS - 1)) begin
          idx_nxt       = '0;
          origin_nxt    = '0;
          fill_base_nxt = tcce_pkg::ADDR_W'(tcce_pkg::BOTTOM_OFS);
          state_nxt     = ST_FILL;
        end else begin
          idx_nxt   = idx_r + tcce_pkg::IDX_W'(1);
          state_nxt = ST_COPY_RD;
        end
      end
      ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = fill_base_r + tcce_pkg::ADDR_W'(idx_r);
        ram_wdata = tcce_pkg::SCROLL_FILL;
        if (idx_r == tcce_pkg::IDX_W'(tcce_pkg::LINE_CHARS - 1)) begin
          state_nxt = ST_DONE;
        end else begin
          idx_nxt = idx_r + tcce_pkg::IDX_W'(1);
        end
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_cur_nxt   = tcce_pkg::ADDR_W'(cur_sum);
          out_org_nxt   = origin_r;
          out_data_nxt  = data_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      row_r       <= '0;
      col_r       <= '0;
      origin_r    <= '0;
      attr_r      <= tcce_pkg::ATTR_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      origin_r    <= origin_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        attr_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    fill_base_r <= fill_base_nxt;
    data_r      <= data_nxt;
    out_cur_r   <= out_cur_nxt;
    out_org_r   <= out_org_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_cursor_address = out_cur_r;
  assign out_display_origin = out_org_r;
  assign out_read_data      = out_data_r;

endmodule

[hw/rtl/tcce_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/tcce_checker.sv]
// Port-level assertions for the text console character engine, with bind.
module tcce_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [tcce_pkg::ADDR_W-1:0]   out_cursor_address,
  input logic [tcce_pkg::ADDR_W-1:0]   out_display_origin,
  input logic [tcce_pkg::WORD_W-1:0]   out_read_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cursor_address)
      && $stable(out_display_origin) && $stable(out_read_data))
    else $error("stalled result changed");

  // reset starts the clearing pass: no input transfer right after reset
  a_reset_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second input transfer taken while busy");

endmodule

bind text_console_char_engine tcce_checker u_tcce_checker (.*);

[tb/text_console_char_engine_check.sv]
// Checker for the text console engine: tracks console state, predicts and compares results.
`timescale 1ns / 100ps
module text_console_char_engine_check
  import tcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic              in_func,
  input  logic [CHAR_W-1:0] in_char_code,
  input  logic [ADDR_W-1:0] in_read_address,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [ADDR_W-1:0] out_cursor_address,
  input  logic [ADDR_W-1:0] out_display_origin,
  input  logic [WORD_W-1:0] out_read_data,
  input  logic              cfg_we,
  input  logic [CHAR_W-1:0] cfg_wdata,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic [ADDR_W-1:0] cursor;
    logic [ADDR_W-1:0] origin;
    logic [WORD_W-1:0] data;
  } console_result_t;

  localparam int REPORT_MAX = 100;

  logic [WORD_W-1:0] vram [VRAM_WORDS];
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [ADDR_W-1:0] origin;
  logic [CHAR_W-1:0] attr;
  console_result_t   due_results [$];
  int                fails = 0;
  int                outstanding = 0;

  assign fail_count    = fails;
  assign pending_count = outstanding;

  task automatic report_mismatch(input string msg);
    if (fails < REPORT_MAX) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    fails++;
  endtask

  function automatic int wrap(input int a);
    return a % VRAM_WORDS;
  endfunction

  function automatic int cursor_word();
    return wrap(int'(origin) + int'(row) * LINE_CHARS + int'(col));
  endfunction

  // step down one row; from the bottom row this scrolls the display
  task automatic line_down();
    int bottom;
    if (row < ROW_W'(SCREEN_ROWS - 1)) begin
      row = row + 1'b1;
    end else begin
      if (int'(origin) + (SCREEN_ROWS + 1) * LINE_CHARS < VRAM_WORDS) begin
        origin = origin + ADDR_W'(LINE_CHARS);
      end else begin
        // no room for another line: move the rows that stay visible to the base
        for (int i = 0; i < COPY_WORDS; i++) begin
          vram[wrap(i)] = vram[wrap(int'(origin) + LINE_CHARS + i)];
        end
        origin = '0;
      end
      bottom = int'(origin) + COPY_WORDS;
      for (int i = 0; i < LINE_CHARS; i++) begin
        vram[wrap(bottom + i)] = SCROLL_FILL;
      end
    end
  endtask

  task automatic advance_console(input logic func, input logic [CHAR_W-1:0] ch,
                                 input logic [ADDR_W-1:0] raddr,
                                 output console_result_t res);
    res.data = '0;
    if (func == FUNC_READ) begin
      res.data = vram[wrap(int'(raddr))];
    end else if (ch == CH_LF) begin
      line_down();
    end else if (ch == CH_CR) begin
      col = '0;
    end else if (ch == CH_BS) begin
      if (col != '0) begin
        col = col - 1'b1;
        vram[cursor_word()] = BLANK_WORD;
      end
    end else begin
      vram[cursor_word()] = {attr, ch};
      if (col == COL_W'(LINE_CHARS - 1)) begin
        col = '0;
        line_down();
      end else begin
        col = col + 1'b1;
      end
    end
    res.cursor = ADDR_W'(cursor_word());
    res.origin = origin;
  endtask

  always @(posedge clk) begin
    console_result_t want;
    if (!rst_n) begin
      foreach (vram[i]) vram[i] = BLANK_WORD;
      row    = '0;
      col    = '0;
      origin = '0;
      attr   = ATTR_RESET;
      due_results.delete();
    end else begin
      if (cfg_we) begin
        attr = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("result transfer with no item outstanding");
        end else begin
          want = due_results.pop_front();
          if (out_cursor_address != want.cursor) begin
            report_mismatch($sformatf("cursor_address %h, expected %h",
                                      out_cursor_address, want.cursor));
          end
          if (out_display_origin != want.origin) begin
            report_mismatch($sformatf("display_origin %h, expected %h",
                                      out_display_origin, want.origin));
          end
          if (out_read_data != want.data) begin
            report_mismatch($sformatf("read_data %h, expected %h",
                                      out_read_data, want.data));
          end
        end
      end
      if (in_valid && !in_stall) begin
        advance_console(in_func, in_char_code, in_read_address, want);
        due_results.push_back(want);
      end
    end
    outstanding = due_results.size();
  end

endmodule

[tb/text_console_char_engine_test.sv]
// Testbench top for the text console engine: stimulus, watchdog and verdict.
`timescale 1ns / 100ps
module text_console_char_engine_test;
  import tcce_pkg::*;

  localparam int CLK_PERIOD   = 10;
  localparam int RESET_CYCLES = 12;
  localparam int PHASES       = 5;
  localparam int PHASE_ITEMS  = 226;
  localparam int IDLE_LIMIT   = 40000;
  localparam int TAIL_CYCLES  = 40;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic              in_func;
  logic [CHAR_W-1:0] in_char_code;
  logic [ADDR_W-1:0] in_read_address;
  logic              out_valid;
  logic              out_stall;
  logic [ADDR_W-1:0] out_cursor_address;
  logic [ADDR_W-1:0] out_display_origin;
  logic [WORD_W-1:0] out_read_data;
  logic              cfg_we;
  logic [CHAR_W-1:0] cfg_wdata;

  int                fail_count;
  int                pending_count;
  int                idle_cycles = 0;
  logic [ADDR_W-1:0] seen_origin = '0;
  bit                calm = 1'b0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  text_console_char_engine u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_char_code      (in_char_code),
    .in_read_address   (in_read_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_address(out_cursor_address),
    .out_display_origin(out_display_origin),
    .out_read_data     (out_read_data),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata)
  );

  text_console_char_engine_check u_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_char_code      (in_char_code),
    .in_read_address   (in_read_address),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_address(out_cursor_address),
    .out_display_origin(out_display_origin),
    .out_read_data     (out_read_data),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .fail_count        (fail_count),
    .pending_count     (pending_count)
  );

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  task automatic send_item(input logic func, input logic [CHAR_W-1:0] ch,
                           input logic [ADDR_W-1:0] addr);
    int gap;
    gap = pick_gap(calm);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_func         <= func;
    in_char_code    <= ch;
    in_read_address <= addr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  task automatic write_attribute(input logic [CHAR_W-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // watchdog on transfers; also remembers the last origin seen for targeted reads
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("text_console_char_engine: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      seen_origin <= out_display_origin;
    end
  end

  // result side back-pressure
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = pick_gap($urandom_range(0, 4) == 0);
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      repeat (($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(0, 5))
        @(negedge clk);
    end
  end

  initial begin
    int                kind;
    int                n;
    int                sent;
    logic [CHAR_W-1:0] c;
    logic [ADDR_W-1:0] a;
    logic [CHAR_W-1:0] phase_attr [PHASES];

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = FUNC_PUT;
    in_char_code    = '0;
    in_read_address = '0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    phase_attr      = '{8'hFF, 8'h00, 8'h00, 8'h7E, 8'h00};
    phase_attr[2]   = CHAR_W'($urandom_range(0, 255));
    phase_attr[4]   = CHAR_W'($urandom_range(0, 255));

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // directed: reset attribute, field extremes, every control code
    send_item(FUNC_READ, 8'h00, '0);
    send_item(FUNC_READ, 8'hFF, '1);
    send_item(FUNC_PUT, CH_BS, '0);     // backspace at column 0 does nothing
    send_item(FUNC_PUT, CH_CR, '0);
    send_item(FUNC_PUT, 8'h41, '0);
    send_item(FUNC_PUT, 8'h00, '0);
    send_item(FUNC_PUT, 8'hFF, '1);
    send_item(FUNC_PUT, 8'h7F, '0);
    send_item(FUNC_PUT, 8'h80, '1);
    send_item(FUNC_READ, 8'h00, 13'd1);
    send_item(FUNC_READ, 8'h00, 13'd2);
    send_item(FUNC_PUT, CH_BS, '0);
    send_item(FUNC_READ, 8'h00, 13'd4);
    send_item(FUNC_PUT, CH_LF, '0);     // column kept
    send_item(FUNC_PUT, 8'h5A, '0);
    send_item(FUNC_PUT, CH_CR, '0);
    send_item(FUNC_PUT, CH_BS, '0);
    send_item(FUNC_READ, 8'h00, 13'd84);

    for (int p = 0; p < PHASES; p++) begin
      write_attribute(phase_attr[p]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(0, 99);
        calm = ($urandom_range(0, 3) == 0);
        if (kind < 25) begin
          // a run of text characters (any code but LF, CR and BS), sometimes past the end of the line
          n = ($urandom_range(0, 7) == 0) ? $urandom_range(70, 100) : $urandom_range(1, 30);
          repeat (n) begin
            do c = CHAR_W'($urandom_range(0, 255));
            while (c == CH_LF || c == CH_CR || c == CH_BS);
            send_item(FUNC_PUT, c, ADDR_W'($urandom));
          end
        end else if (kind < 50) begin
          // line feeds; long bursts push the origin around memory
          n = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 4);
          repeat (n) send_item(FUNC_PUT, CH_LF, ADDR_W'($urandom));
        end else if (kind < 56) begin
          n = 1;
          send_item(FUNC_PUT, CH_CR, ADDR_W'($urandom));
        end else if (kind < 64) begin
          n = $urandom_range(1, 6);
          repeat (n) send_item(FUNC_PUT, CH_BS, ADDR_W'($urandom));
        end else if (kind < 92) begin
          n = $urandom_range(1, 6);
          repeat (n) begin
            case ($urandom_range(0, 2))
              0: a = ADDR_W'($urandom);
              1: a = ADDR_W'(int'(seen_origin) + $urandom_range(0, SCREEN_ROWS * LINE_CHARS));
              default: a = ADDR_W'($urandom_range(0, COPY_WORDS + LINE_CHARS - 1));
            endcase
            send_item(FUNC_READ, CHAR_W'($urandom), a);
          end
        end else begin
          n = $urandom_range(1, 3);
          repeat (n) send_item(1'($urandom), CHAR_W'($urandom), ADDR_W'($urandom));
        end
        sent += n;
      end
    end
    calm = 1'b0;

    drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("text_console_char_engine: match");
    end else begin
      $display("text_console_char_engine: mismatch");
    end
    $finish;
  end

endmodule
